FILE: sv/rgcl_pkg.sv
// Shared types and constants for the radial grid cell locator.
// Used by rgcl_dp, rgcl_ctrl and radial_grid_cell_locator; depends on nothing.
package rgcl_pkg;

    // Table depth and derived widths
    localparam int MAX_RINGS = 1024;
    localparam int IDX_W     = $clog2(MAX_RINGS);
    localparam int N_W       = $clog2(MAX_RINGS + 1);
    localparam int RAW_W     = 36;

    // Field widths
    localparam int OP_W   = 2;
    localparam int Q_W    = 32;
    localparam int CFG_IW = 3;

    // ln(2) in Q0.32
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CENTRE = 2'd0;
    localparam logic [OP_W-1:0] OP_EDGE   = 2'd1;

    // Grid modes
    localparam logic [1:0] MODE_LOG    = 2'd0;
    localparam logic [1:0] MODE_EXP    = 2'd1;
    localparam logic [1:0] MODE_ARITH  = 2'd2;
    localparam logic [1:0] MODE_CUSTOM = 2'd3;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_GRID_MODE   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_INNER       = 3'd1;
    localparam logic [CFG_IW-1:0] REG_OFFSET      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RING_COUNT  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_INV_SPACING = 3'd4;
    localparam logic [CFG_IW-1:0] REG_INV_LOG_GR  = 3'd5;
    localparam logic [CFG_IW-1:0] REG_SCALE       = 3'd6;
    localparam logic [CFG_IW-1:0] REG_LOG_INNER   = 3'd7;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_WRITE, S_PREP, S_NORM, S_LOADM, S_SQR,
        S_LNMUL, S_LNRND, S_LNADJ, S_IDXMUL, S_IDXFIN, S_CHK_RD, S_CHK_CMP,
        S_SRCH_RD, S_SRCH_CMP, S_CLAMP, S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MS_ARG, MS_LN, MS_IDX
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     ram_write;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     prep_x;
        logic     raw_neg1;
        logic     raw_arith;
        logic     norm_step;
        logic     load_m;
        logic     sq_step;
        logic     ln_round;
        logic     ln_adjust;
        logic     raw_idx;
        logic     raw_chk;
        logic     srch_clr;
        logic     srch_inc;
        logic     raw_srch;
        logic     res_clamp;
        logic     res_zero;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      mode;
        logic            arg_bad;
        logic            norm_last;
        logic            sq_last;
        logic            raw_in_range;
        logic            srch_end;
        logic            rd_lt;
        logic            out_free;
    } st_t;

endpackage

FILE: sv/rgcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/rgcl_dp.sv
// Datapath: configuration registers, request capture, multiplier, log unit,
// index arithmetic, the two radius tables and the result registers.
// Depends on rgcl_pkg and rgcl_ram.
module rgcl_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rgcl_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [rgcl_pkg::Q_W-1:0]      cfg_data,
    input  logic [rgcl_pkg::OP_W-1:0]     op,
    input  logic [rgcl_pkg::Q_W-1:0]      radius,
    input  logic [rgcl_pkg::IDX_W-1:0]    entry_index,
    input  logic [rgcl_pkg::Q_W-1:0]      entry_value,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [rgcl_pkg::IDX_W-1:0]    cell_index,
    output logic                          was_clamped,
    input  rgcl_pkg::cmd_t                cmd,
    output rgcl_pkg::st_t                 st
);
    import rgcl_pkg::*;

    // Configuration
    logic [1:0]       mode_reg;
    logic [Q_W-1:0]   inner_reg;
    logic [IDX_W-1:0] off_reg;
    logic [N_W-1:0]   rc_reg;
    logic [Q_W-1:0]   isp_reg;
    logic [Q_W-1:0]   ilg_reg;
    logic [Q_W-1:0]   scale_reg;
    logic [Q_W-1:0]   lir_reg;

    // Captured request
    logic [OP_W-1:0]  op_reg;
    logic [Q_W-1:0]   rad_reg;
    logic [IDX_W-1:0] ei_reg;
    logic [Q_W-1:0]   ev_reg;

    // Working registers
    logic signed [67:0] p_reg;
    logic [63:0]        x_reg;
    logic [5:0]         sh_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        m_reg;
    logic [6:0]         int_reg;
    logic [23:0]        frac_reg;
    logic [33:0]        lnv_reg;
    logic [RAW_W-1:0]   raw_reg;
    logic [N_W-1:0]     srch_reg;
    logic [IDX_W-1:0]   res_cell_reg;
    logic               res_clamp_reg;
    logic [IDX_W-1:0]   out_cell_reg;
    logic               out_clamp_reg;
    logic               out_valid_reg;

    logic [RAW_W-1:0]   raw_next;

    // Effective ring count: zero acts as one, capped at the table depth
    logic [N_W-1:0] n_eff;
    always_comb
    begin
        if (rc_reg == '0)
            n_eff = N_W'(1);
        else if (rc_reg > N_W'(MAX_RINGS))
            n_eff = N_W'(MAX_RINGS);
        else
            n_eff = rc_reg;
    end

    // Radius against inner radius
    logic        ge;
    logic [31:0] delta;
    assign ge    = rad_reg >= inner_reg;
    assign delta = ge ? (rad_reg - inner_reg) : (inner_reg - rad_reg);

    // Shared multiplier
    logic signed [33:0] mul_a, mul_b;
    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_ARG:
            begin
                if (mode_reg == MODE_LOG)
                begin
                    mul_a = $signed({2'b00, rad_reg});
                    mul_b = (op_reg == OP_CENTRE) ? $signed({2'b00, scale_reg})
                                                  : 34'sh10000;
                end
                else
                begin
                    mul_a = $signed({2'b00, delta});
                    mul_b = (mode_reg == MODE_ARITH) ? $signed({2'b00, isp_reg})
                                                     : $signed({2'b00, scale_reg});
                end
            end
            MS_LN:
            begin
                mul_a = $signed({{3{int_reg[6]}}, int_reg, frac_reg});
                mul_b = $signed({2'b00, LN2_Q32});
            end
            MS_IDX:
            begin
                mul_a = $signed(lnv_reg);
                mul_b = $signed({{2{ilg_reg[31]}}, ilg_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Log argument checks and preparation
    logic        arg_bad;
    logic [63:0] x_prep;
    always_comb
    begin
        arg_bad = 1'b0;
        x_prep  = p_reg[63:0];
        if (mode_reg == MODE_LOG)
            arg_bad = (p_reg[63:0] == 64'd0);
        else if (mode_reg == MODE_EXP)
        begin
            if (ge)
                x_prep = p_reg[63:0] + 64'h1_0000_0000;
            else
            begin
                arg_bad = (p_reg[63:32] != 32'd0);
                x_prep  = 64'h1_0000_0000 - p_reg[63:0];
            end
        end
    end

    // Arithmetic floor, rounded toward minus infinity below the inner radius
    logic [RAW_W-1:0] ar_hi, ar_fl;
    assign ar_hi = {4'b0, p_reg[63:32]} + {{(RAW_W-1){1'b0}}, (p_reg[31:0] != 32'd0) && !ge};
    assign ar_fl = ge ? ar_hi : (~ar_hi + RAW_W'(1));

    // Normalize step: shift amount halves each cycle
    logic [5:0]  amt;
    logic        top_zero;
    assign amt      = 6'd32 >> cnt_reg[2:0];
    assign top_zero = (x_reg >> (7'd64 - {1'b0, amt})) == 64'd0;

    // Squaring step
    logic [63:0] sq;
    logic [32:0] sq_t;
    assign sq   = m_reg * m_reg;
    assign sq_t = sq[63:31];

    // Round to Q16.16, ties away from zero
    logic [67:0] mag, rnd;
    logic [33:0] q_ext;
    assign mag   = p_reg[67] ? (~p_reg + 68'sd1) : p_reg;
    assign rnd   = mag + (68'd1 << 39);
    assign q_ext = {10'b0, rnd[63:40]};

    // Table read
    logic             wr_ok;
    logic [IDX_W-1:0] raddr;
    logic [Q_W-1:0]   ctr_rd, edg_rd, rd;
    assign wr_ok = {1'b0, ei_reg} < N_W'(MAX_RINGS);
    assign raddr = (mode_reg == MODE_CUSTOM) ? srch_reg[IDX_W-1:0] : raw_reg[IDX_W-1:0];
    assign rd    = op_reg[0] ? edg_rd : ctr_rd;

    rgcl_ram #(.WIDTH(Q_W), .DEPTH(MAX_RINGS)) u_ctr_ram (
        .clk   (clk),
        .we    (cmd.ram_write && !op_reg[0] && wr_ok),
        .waddr (ei_reg),
        .wdata (ev_reg),
        .raddr (raddr),
        .rdata (ctr_rd)
    );

    rgcl_ram #(.WIDTH(Q_W), .DEPTH(MAX_RINGS)) u_edg_ram (
        .clk   (clk),
        .we    (cmd.ram_write && op_reg[0] && wr_ok),
        .waddr (ei_reg),
        .wdata (ev_reg),
        .raddr (raddr),
        .rdata (edg_rd)
    );

    // Raw index update
    always_comb
    begin
        raw_next = raw_reg;
        if (cmd.raw_neg1)
            raw_next = '1;
        else if (cmd.raw_arith)
            raw_next = ar_fl - {{(RAW_W-IDX_W){1'b0}}, off_reg} + RAW_W'(1);
        else if (cmd.raw_idx)
            raw_next = p_reg[67:32] - {{(RAW_W-IDX_W){1'b0}}, off_reg} + RAW_W'(1);
        else if (cmd.raw_chk && (rd > rad_reg))
            raw_next = raw_reg - RAW_W'(1);
        else if (cmd.raw_srch)
            raw_next = {{(RAW_W-N_W){1'b0}}, srch_reg} - RAW_W'(1);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_LOG;
            inner_reg <= 32'h0001_0000;
            off_reg   <= '0;
            rc_reg    <= N_W'(128);
            isp_reg   <= 32'h0001_0000;
            ilg_reg   <= 32'h0001_0000;
            scale_reg <= 32'h0001_0000;
            lir_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_MODE:   mode_reg  <= cfg_data[1:0];
                REG_INNER:       inner_reg <= cfg_data;
                REG_OFFSET:      off_reg   <= cfg_data[IDX_W-1:0];
                REG_RING_COUNT:  rc_reg    <= cfg_data[N_W-1:0];
                REG_INV_SPACING: isp_reg   <= cfg_data;
                REG_INV_LOG_GR:  ilg_reg   <= cfg_data;
                REG_SCALE:       scale_reg <= cfg_data;
                REG_LOG_INNER:   lir_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= op;
            rad_reg <= radius;
            ei_reg  <= entry_index;
            ev_reg  <= entry_value;
        end
        if (cmd.mul_en)
            p_reg <= mul_a * mul_b;
        if (cmd.prep_x)
        begin
            x_reg  <= x_prep;
            sh_reg <= '0;
        end
        else if (cmd.norm_step && top_zero)
        begin
            x_reg  <= x_reg << amt;
            sh_reg <= sh_reg + amt;
        end
        if (cmd.prep_x || cmd.load_m)
            cnt_reg <= '0;
        else if (cmd.norm_step || cmd.sq_step)
            cnt_reg <= cnt_reg + 5'd1;
        if (cmd.load_m)
        begin
            m_reg    <= x_reg[63:32];
            int_reg  <= 7'd31 - {1'b0, sh_reg};
            frac_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            m_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
            frac_reg <= {frac_reg[22:0], sq_t[32]};
        end
        if (cmd.ln_round)
            lnv_reg <= p_reg[67] ? (~q_ext + 34'd1) : q_ext;
        else if (cmd.ln_adjust)
            lnv_reg <= lnv_reg - {{2{lir_reg[31]}}, lir_reg};
        raw_reg <= raw_next;
        if (cmd.srch_clr)
            srch_reg <= '0;
        else if (cmd.srch_inc)
            srch_reg <= srch_reg + N_W'(1);
        // Clamp to the rings in use
        if (cmd.res_zero)
        begin
            res_cell_reg  <= '0;
            res_clamp_reg <= 1'b0;
        end
        else if (cmd.res_clamp)
        begin
            if (raw_reg[RAW_W-1])
            begin
                res_cell_reg  <= '0;
                res_clamp_reg <= 1'b1;
            end
            else if (raw_reg >= {{(RAW_W-N_W){1'b0}}, n_eff})
            begin
                res_cell_reg  <= IDX_W'(n_eff - N_W'(1));
                res_clamp_reg <= 1'b1;
            end
            else
            begin
                res_cell_reg  <= raw_reg[IDX_W-1:0];
                res_clamp_reg <= 1'b0;
            end
        end
        if (cmd.out_load)
        begin
            out_cell_reg  <= res_cell_reg;
            out_clamp_reg <= res_clamp_reg;
        end
    end

    // Status to controller
    assign st.op           = op_reg;
    assign st.mode         = mode_reg;
    assign st.arg_bad      = arg_bad;
    assign st.norm_last    = cnt_reg == 5'd5;
    assign st.sq_last      = cnt_reg == 5'd23;
    assign st.raw_in_range = !raw_reg[RAW_W-1]
                             && (raw_reg < {{(RAW_W-N_W){1'b0}}, n_eff});
    assign st.srch_end     = srch_reg == n_eff;
    assign st.rd_lt        = rd < rad_reg;
    assign st.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign cell_index  = out_cell_reg;
    assign was_clamped = out_clamp_reg;

endmodule

FILE: sv/rgcl_ctrl.sv
// Controller state machine: sequences capture, table writes, log, index,
// table checks, search and result delivery. Depends on rgcl_pkg.
module rgcl_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rgcl_pkg::st_t  st,
    output rgcl_pkg::cmd_t cmd
);
    import rgcl_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MS_ARG;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.op[1])
                    state_next = S_WRITE;
                else if (st.mode == MODE_CUSTOM)
                begin
                    cmd.srch_clr = 1'b1;
                    state_next   = S_SRCH_RD;
                end
                else
                begin
                    cmd.mul_en = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_WRITE:
            begin
                cmd.ram_write = 1'b1;
                cmd.res_zero  = 1'b1;
                state_next    = S_DONE;
            end
            S_PREP:
            begin
                if (st.mode == MODE_ARITH)
                begin
                    cmd.raw_arith = 1'b1;
                    state_next    = (st.op == OP_CENTRE) ? S_CHK_RD : S_CLAMP;
                end
                else if (st.arg_bad)
                begin
                    cmd.raw_neg1 = 1'b1;
                    state_next   = S_CLAMP;
                end
                else
                begin
                    cmd.prep_x = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.norm_step = 1'b1;
                if (st.norm_last)
                    state_next = S_LOADM;
            end
            S_LOADM:
            begin
                cmd.load_m = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.sq_step = 1'b1;
                if (st.sq_last)
                    state_next = S_LNMUL;
            end
            S_LNMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_LN;
                state_next  = S_LNRND;
            end
            S_LNRND:
            begin
                cmd.ln_round = 1'b1;
                state_next   = (st.mode == MODE_LOG && st.op == OP_EDGE) ? S_LNADJ
                                                                         : S_IDXMUL;
            end
            S_LNADJ:
            begin
                cmd.ln_adjust = 1'b1;
                state_next    = S_IDXMUL;
            end
            S_IDXMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_IDX;
                state_next  = S_IDXFIN;
            end
            S_IDXFIN:
            begin
                cmd.raw_idx = 1'b1;
                state_next  = (st.mode == MODE_EXP && st.op == OP_CENTRE) ? S_CHK_RD
                                                                          : S_CLAMP;
            end
            S_CHK_RD:
            begin
                state_next = st.raw_in_range ? S_CHK_CMP : S_CLAMP;
            end
            S_CHK_CMP:
            begin
                cmd.raw_chk = 1'b1;
                state_next  = S_CLAMP;
            end
            S_SRCH_RD:
            begin
                if (st.srch_end)
                begin
                    cmd.raw_srch = 1'b1;
                    state_next   = S_CLAMP;
                end
                else
                    state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (st.rd_lt)
                begin
                    cmd.srch_inc = 1'b1;
                    state_next   = S_SRCH_RD;
                end
                else
                begin
                    cmd.raw_srch = 1'b1;
                    state_next   = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cmd.res_clamp = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/radial_grid_cell_locator.sv
// Top level of the radial grid cell locator: controller plus datapath.
// Depends on rgcl_pkg, rgcl_ctrl, rgcl_dp (and rgcl_ram through rgcl_dp).
//
//  Channel   Signals                                          Transfer
//  request   in_valid/in_ready, op radius entry_index
//            entry_value                                      valid & ready
//  result    out_valid/out_ready, cell_index was_clamped      valid & ready
//  config    cfg_we, cfg_index, cfg_data                      cfg_we high
//
// One request at a time. Log and exponential lookups run the 6-step
// normalizer and the 24-step squaring loop, both skipped when the log
// argument is zero or below; custom search compares table entries in turn
// until one is not below the radius or it runs off the end. A finished
// result waits in the output register while the next request is taken.
// Reset is asynchronous, active low, and leaves the tables unwritten.
module radial_grid_cell_locator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rgcl_pkg::CFG_IW-1:0] cfg_index,
    input  logic [rgcl_pkg::Q_W-1:0]    cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rgcl_pkg::OP_W-1:0]   op,
    input  logic [rgcl_pkg::Q_W-1:0]    radius,
    input  logic [rgcl_pkg::IDX_W-1:0]  entry_index,
    input  logic [rgcl_pkg::Q_W-1:0]    entry_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rgcl_pkg::IDX_W-1:0]  cell_index,
    output logic                        was_clamped
);
    import rgcl_pkg::*;

    cmd_t cmd;
    st_t  st;

    rgcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    rgcl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .radius      (radius),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .cell_index  (cell_index),
        .was_clamped (was_clamped),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
